// ----- rtl/ctawt_pkg.sv -----
package ctawt_pkg;

    localparam int CNT_W  = 16;
    localparam int OFF_W  = 6;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int MODE_W = 3;
    localparam int OP_W   = 4;
    localparam int IDX_W  = 2;

    localparam logic [OFF_W-1:0]  OFF_DELAY_RST   = 6'd30;
    localparam logic [CNT_W-1:0]  ALARM_DELAY_RST = 16'd60;
    localparam logic [CNT_W-1:0]  WAKE_DELAY_RST  = 16'd60;
    localparam logic [HOUR_W-1:0] HOUR_MAX        = 5'd23;
    localparam logic [HOUR_W-1:0] HOUR_RST        = 5'd12;
    localparam logic [MIN_W-1:0]  MINUTE_MAX      = 6'd59;

    // Register map indexes (byte address is 4 times the index).
    localparam logic [IDX_W-1:0] REG_OFF_DELAY   = 2'd0;
    localparam logic [IDX_W-1:0] REG_ALARM_DELAY = 2'd1;
    localparam logic [IDX_W-1:0] REG_WAKE_DELAY  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK         = 4'd0,
        OP_ALARM_ARM    = 4'd1,
        OP_ALARM_CANCEL = 4'd2,
        OP_WAKE_ARM     = 4'd3,
        OP_WAKE_CANCEL  = 4'd4,
        OP_SHOW         = 4'd5,
        OP_HIDE         = 4'd6,
        OP_AWAKE        = 4'd7,
        OP_SETUP_NEXT   = 4'd8,
        OP_SETUP_BLINK  = 4'd9,
        OP_SETUP_ADJUST = 4'd10,
        OP_SETUP_EXIT   = 4'd11
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE   = 3'd0,
        MODE_HOUR   = 3'd1,
        MODE_MINUTE = 3'd2,
        MODE_YEAR   = 3'd3,
        MODE_MONTH  = 3'd4,
        MODE_DAY    = 3'd5
    } mode_t;

    typedef struct packed {
        logic [OFF_W-1:0] off_delay;
        logic [CNT_W-1:0] alarm_delay;
        logic [CNT_W-1:0] wake_delay;
    } cfg_t;

    // Write-back of a renormalized timer count from the remainder unit.
    typedef struct packed {
        logic             valid;
        logic             wake;
        logic [CNT_W-1:0] value;
    } rem_wr_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic              show_hour;
        logic              show_minute;
        logic              show_dot;
        logic              show_wake_mark;
        logic              display_refresh;
        logic              display_off;
        logic              alarm_fired;
        logic              wake_fired;
        logic [CNT_W-1:0]  wake_remaining;
        logic [MODE_W-1:0] edit_mode;
    } result_t;

endpackage

// ----- rtl/ctawt_rem.sv -----
module ctawt_rem (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ctawt_pkg::CNT_W-1:0] dividend,
    input  logic [ctawt_pkg::CNT_W-1:0] divisor,
    output logic                       busy,
    output logic                       done,
    output logic [ctawt_pkg::CNT_W-1:0] result
);
    import ctawt_pkg::*;

    localparam int STEP_W = $clog2(CNT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CNT_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W:0]    trial;

    assign trial = {rem_reg, dvd_reg[CNT_W-1]};

    // Restoring remainder, one quotient bit per cycle.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[CNT_W-1:0];
            end
            dvd_next  = {dvd_reg[CNT_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = rem_reg;

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg && (div_reg != '0) |-> rem_reg < div_reg)
        else $error("remainder not below divisor");

    a_busy_done_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(busy_reg && done_reg))
        else $error("remainder unit busy and done together");

endmodule

// ----- rtl/ctawt_core.sv -----
module ctawt_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_accept,
    input  ctawt_pkg::op_t              op,
    input  logic                        normal_mode,
    input  logic                        sign,
    input  ctawt_pkg::cfg_t             cfg,
    input  ctawt_pkg::rem_wr_t          rem_wr,
    output ctawt_pkg::result_t          result,
    output logic [ctawt_pkg::CNT_W-1:0] alarm_raw,
    output logic [ctawt_pkg::CNT_W-1:0] wake_raw
);
    import ctawt_pkg::*;

    logic [MIN_W-1:0]  seconds_reg, seconds_next;
    logic [MIN_W-1:0]  minutes_reg, minutes_next;
    logic [HOUR_W-1:0] hours_reg, hours_next;
    logic              hour_lit_reg, hour_lit_next;
    logic              minute_lit_reg, minute_lit_next;
    logic              dot_lit_reg, dot_lit_next;
    logic              alarm_armed_reg, alarm_armed_next;
    logic              wake_armed_reg, wake_armed_next;
    logic              visible_reg, visible_next;
    logic              disp_en_reg, disp_en_next;
    logic [OFF_W-1:0]  blank_reg, blank_next;
    logic [CNT_W-1:0]  alarm_raw_reg, alarm_raw_next;
    logic [CNT_W-1:0]  alarm_red_reg, alarm_red_next;
    logic [CNT_W-1:0]  wake_raw_reg, wake_raw_next;
    logic [CNT_W-1:0]  wake_red_reg, wake_red_next;
    mode_t             mode_reg, mode_next;

    logic [OFF_W-1:0]  blank_inc;
    logic [CNT_W:0]    alarm_inc;
    logic [CNT_W:0]    wake_inc;
    logic [CNT_W-1:0]  alarm_step;
    logic [CNT_W-1:0]  wake_step;
    logic [MODE_W:0]   mode_inc;
    logic              refresh, off, afire, wfire;
    logic              dh, dm, dd, dw;

    assign blank_inc = blank_reg + 1'b1;
    assign alarm_inc = {1'b0, alarm_red_reg} + 1'b1;
    assign wake_inc  = {1'b0, wake_red_reg} + 1'b1;
    assign mode_inc  = {1'b0, mode_reg} + 1'b1;

    // The reduced count is always below the delay, so the next count wraps
    // exactly when it reaches the delay. A zero delay always yields zero.
    assign alarm_step = ((cfg.alarm_delay == '0) || (alarm_inc == {1'b0, cfg.alarm_delay}))
                        ? '0 : alarm_inc[CNT_W-1:0];
    assign wake_step  = ((cfg.wake_delay == '0) || (wake_inc == {1'b0, cfg.wake_delay}))
                        ? '0 : wake_inc[CNT_W-1:0];

    always_comb begin
        seconds_next     = seconds_reg;
        minutes_next     = minutes_reg;
        hours_next       = hours_reg;
        hour_lit_next    = hour_lit_reg;
        minute_lit_next  = minute_lit_reg;
        dot_lit_next     = dot_lit_reg;
        alarm_armed_next = alarm_armed_reg;
        wake_armed_next  = wake_armed_reg;
        visible_next     = visible_reg;
        disp_en_next     = disp_en_reg;
        blank_next       = blank_reg;
        alarm_raw_next   = alarm_raw_reg;
        alarm_red_next   = alarm_red_reg;
        wake_raw_next    = wake_raw_reg;
        wake_red_next    = wake_red_reg;
        mode_next        = mode_reg;
        refresh          = 1'b0;
        off              = 1'b0;
        afire            = 1'b0;
        wfire            = 1'b0;
        dh               = 1'b0;
        dm               = 1'b0;
        dd               = 1'b0;
        dw               = 1'b0;

        case (op)
            OP_TICK: begin
                if (seconds_reg >= MINUTE_MAX) begin
                    seconds_next = '0;
                    if (minutes_reg >= MINUTE_MAX) begin
                        minutes_next = '0;
                        hours_next   = (hours_reg >= HOUR_MAX) ? '0 : hours_reg + 1'b1;
                    end else begin
                        minutes_next = minutes_reg + 1'b1;
                    end
                end else begin
                    seconds_next = seconds_reg + 1'b1;
                end
                if (normal_mode) begin
                    if (blank_reg < cfg.off_delay) begin
                        blank_next = blank_inc;
                        if ((blank_inc >= cfg.off_delay) && visible_reg
                            && (mode_reg == MODE_NONE)) begin
                            disp_en_next = 1'b0;
                            off          = 1'b1;
                        end
                    end
                    if (alarm_armed_reg) begin
                        alarm_raw_next = alarm_step;
                        alarm_red_next = alarm_step;
                        if (alarm_step == '0) begin
                            alarm_armed_next = 1'b0;
                            afire            = 1'b1;
                        end
                    end
                    dot_lit_next = !dot_lit_reg;
                    if (mode_reg == MODE_NONE) begin
                        hour_lit_next   = 1'b1;
                        minute_lit_next = 1'b1;
                        if (visible_reg && disp_en_next) begin
                            refresh = 1'b1;
                            dh      = 1'b1;
                            dm      = 1'b1;
                            dd      = dot_lit_next;
                            dw      = wake_armed_reg;
                        end
                    end
                    if ((seconds_next == '0) && wake_armed_reg) begin
                        wake_raw_next = wake_step;
                        wake_red_next = wake_step;
                        if (wake_step == '0) begin
                            wake_armed_next = 1'b0;
                            wfire           = 1'b1;
                        end
                    end
                end
            end
            OP_ALARM_ARM: begin
                if (!alarm_armed_reg) begin
                    alarm_raw_next   = '0;
                    alarm_red_next   = '0;
                    alarm_armed_next = 1'b1;
                end
            end
            OP_ALARM_CANCEL: alarm_armed_next = 1'b0;
            OP_WAKE_ARM: begin
                if (!wake_armed_reg) begin
                    wake_raw_next   = '0;
                    wake_red_next   = '0;
                    wake_armed_next = 1'b1;
                end
            end
            OP_WAKE_CANCEL: wake_armed_next = 1'b0;
            OP_SHOW:        visible_next = 1'b1;
            OP_HIDE:        visible_next = 1'b0;
            OP_AWAKE: begin
                disp_en_next = 1'b1;
                blank_next   = '0;
            end
            OP_SETUP_NEXT: begin
                mode_next    = (mode_inc > 4'(MODE_DAY)) ? MODE_HOUR
                                                         : mode_t'(mode_inc[MODE_W-1:0]);
                visible_next = (mode_next == MODE_HOUR) || (mode_next == MODE_MINUTE);
            end
            OP_SETUP_BLINK: begin
                if ((mode_reg == MODE_HOUR) || (mode_reg == MODE_MINUTE)) begin
                    if (mode_reg == MODE_MINUTE) begin
                        hour_lit_next   = 1'b1;
                        minute_lit_next = !minute_lit_reg;
                    end else begin
                        minute_lit_next = 1'b1;
                        hour_lit_next   = !hour_lit_reg;
                    end
                    if (disp_en_reg) begin
                        refresh = 1'b1;
                        dh      = hour_lit_next;
                        dm      = minute_lit_next;
                        dd      = dot_lit_reg;
                        dw      = 1'b0;
                    end
                end
            end
            OP_SETUP_ADJUST: begin
                if (mode_reg == MODE_MINUTE) begin
                    if (sign) begin
                        minutes_next = ((minutes_reg == '0) || (minutes_reg > MINUTE_MAX))
                                       ? MINUTE_MAX : minutes_reg - 1'b1;
                    end else begin
                        minutes_next = (minutes_reg >= MINUTE_MAX) ? '0 : minutes_reg + 1'b1;
                    end
                    seconds_next = '0;
                end else if (mode_reg == MODE_HOUR) begin
                    if (sign) begin
                        hours_next = ((hours_reg == '0) || (hours_reg > HOUR_MAX))
                                     ? HOUR_MAX : hours_reg - 1'b1;
                    end else begin
                        hours_next = (hours_reg >= HOUR_MAX) ? '0 : hours_reg + 1'b1;
                    end
                end
            end
            OP_SETUP_EXIT: mode_next = MODE_NONE;
            default: begin
            end
        endcase

        if (!refresh) begin
            dh = hour_lit_next;
            dm = minute_lit_next;
            dd = dot_lit_next;
            dw = wake_armed_next;
        end

        result.hour            = hours_next;
        result.minute          = minutes_next;
        result.show_hour       = dh;
        result.show_minute     = dm;
        result.show_dot        = dd;
        result.show_wake_mark  = dw;
        result.display_refresh = refresh;
        result.display_off     = off;
        result.alarm_fired     = afire;
        result.wake_fired      = wfire;
        result.wake_remaining  = wake_armed_next ? CNT_W'(cfg.wake_delay - wake_raw_next) : '0;
        result.edit_mode       = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seconds_reg     <= '0;
            minutes_reg     <= '0;
            hours_reg       <= HOUR_RST;
            hour_lit_reg    <= 1'b1;
            minute_lit_reg  <= 1'b1;
            dot_lit_reg     <= 1'b0;
            alarm_armed_reg <= 1'b0;
            wake_armed_reg  <= 1'b0;
            visible_reg     <= 1'b0;
            disp_en_reg     <= 1'b1;
            blank_reg       <= '0;
            alarm_raw_reg   <= '0;
            alarm_red_reg   <= '0;
            wake_raw_reg    <= '0;
            wake_red_reg    <= '0;
            mode_reg        <= MODE_NONE;
        end else if (in_accept) begin
            seconds_reg     <= seconds_next;
            minutes_reg     <= minutes_next;
            hours_reg       <= hours_next;
            hour_lit_reg    <= hour_lit_next;
            minute_lit_reg  <= minute_lit_next;
            dot_lit_reg     <= dot_lit_next;
            alarm_armed_reg <= alarm_armed_next;
            wake_armed_reg  <= wake_armed_next;
            visible_reg     <= visible_next;
            disp_en_reg     <= disp_en_next;
            blank_reg       <= blank_next;
            alarm_raw_reg   <= alarm_raw_next;
            alarm_red_reg   <= alarm_red_next;
            wake_raw_reg    <= wake_raw_next;
            wake_red_reg    <= wake_red_next;
            mode_reg        <= mode_next;
        end else if (rem_wr.valid) begin
            if (rem_wr.wake) begin
                wake_red_reg <= rem_wr.value;
            end else begin
                alarm_red_reg <= rem_wr.value;
            end
        end
    end

    assign alarm_raw = alarm_raw_reg;
    assign wake_raw  = wake_raw_reg;

    a_hours_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (hours_reg <= HOUR_MAX) && (minutes_reg <= MINUTE_MAX) && (seconds_reg <= MINUTE_MAX))
        else $error("time of day out of range");

    a_no_writeback_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |-> !rem_wr.valid)
        else $error("count write-back collides with an accepted transaction");

endmodule

// ----- rtl/ctawt_skid.sv -----
module ctawt_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ctawt_pkg::result_t push_data,
    output logic               push_ready,
    output logic               out_valid,
    output ctawt_pkg::result_t out_data,
    input  logic               out_ready
);
    import ctawt_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop = main_valid_reg && out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held while output register is empty");

endmodule

// ----- rtl/clock_tick_alarm_wakeup_timer_core.sv -----
// Time-of-day clock with display blanking, a one-shot alarm in seconds and a
// one-shot wake-up timer in minutes. Each input transaction carries one command
// (tick, arm, cancel, show, hide, awake or a setup step) and produces exactly
// one result transaction with the time, the display flags and the timer events.
// The block takes one input transaction per clock cycle unless s_tready is held
// low; results sit in a two-entry output buffer, so a new transaction is
// accepted while an earlier result still waits on the master side. After a
// write to alarm_delay or wakeup_delay the running count of that timer is
// reduced modulo the new delay by a bit-serial remainder unit; the slave side
// is held off (s_tready low) until that is done, while register writes and
// reads keep working. Registers sit at byte addresses 0x0 (display_off_delay),
// 0x4 (alarm_delay) and 0x8 (wakeup_delay).
module clock_tick_alarm_wakeup_timer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] op, [4] normal_mode, [5] sign, [7:6] zero
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] hour, [10:5] minute, [11] show_hour, [12] show_minute,
    // [13] show_dot, [14] show_wake_mark, [15] display_refresh,
    // [16] display_off, [17] alarm_fired, [18] wake_fired,
    // [34:19] wake_remaining, [37:35] edit_mode, [39:38] zero
    output logic [39:0] m_tdata,
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ctawt_pkg::*;

    cfg_t             cfg_reg, cfg_next;
    logic             pend_alarm_reg, pend_alarm_next;
    logic             pend_wake_reg, pend_wake_next;
    logic             job_wake_reg, job_wake_next;
    logic [IDX_W-1:0] reg_idx;
    logic             cfg_wr;
    logic             rem_start, start_wake, rem_busy, rem_done;
    logic [CNT_W-1:0] rem_result;
    logic [CNT_W-1:0] alarm_raw, wake_raw;
    rem_wr_t          rem_wr;
    result_t          core_result, out_result;
    logic             skid_ready, s_accept;

    // The register port never waits.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_OFF_DELAY:   cfg_next.off_delay   = pwdata[OFF_W-1:0];
                REG_ALARM_DELAY: cfg_next.alarm_delay = pwdata[CNT_W-1:0];
                REG_WAKE_DELAY:  cfg_next.wake_delay  = pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OFF_DELAY:   prdata = {26'd0, cfg_reg.off_delay};
            REG_ALARM_DELAY: prdata = {16'd0, cfg_reg.alarm_delay};
            REG_WAKE_DELAY:  prdata = {16'd0, cfg_reg.wake_delay};
            default:         prdata = '0;
        endcase
    end

    // A written delay marks its timer for renormalization. The alarm goes
    // first when both are pending; a write that lands while its own job runs
    // marks it again, so the last written value always wins.
    assign rem_start  = !rem_busy && (pend_alarm_reg || pend_wake_reg);
    assign start_wake = !pend_alarm_reg;

    always_comb begin
        pend_alarm_next = (pend_alarm_reg && !(rem_start && !start_wake))
                          || (cfg_wr && (reg_idx == REG_ALARM_DELAY));
        pend_wake_next  = (pend_wake_reg && !(rem_start && start_wake))
                          || (cfg_wr && (reg_idx == REG_WAKE_DELAY));
        job_wake_next   = rem_start ? start_wake : job_wake_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.off_delay   <= OFF_DELAY_RST;
            cfg_reg.alarm_delay <= ALARM_DELAY_RST;
            cfg_reg.wake_delay  <= WAKE_DELAY_RST;
            pend_alarm_reg      <= 1'b0;
            pend_wake_reg       <= 1'b0;
            job_wake_reg        <= 1'b0;
        end else begin
            cfg_reg        <= cfg_next;
            pend_alarm_reg <= pend_alarm_next;
            pend_wake_reg  <= pend_wake_next;
            job_wake_reg   <= job_wake_next;
        end
    end

    ctawt_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (start_wake ? wake_raw : alarm_raw),
        .divisor  (start_wake ? cfg_reg.wake_delay : cfg_reg.alarm_delay),
        .busy     (rem_busy),
        .done     (rem_done),
        .result   (rem_result)
    );

    assign rem_wr.valid = rem_done;
    assign rem_wr.wake  = job_wake_reg;
    assign rem_wr.value = rem_result;

    // Input is held off while a renormalization is pending, running or
    // writing back, and while the output buffer is full.
    assign s_tready = skid_ready && !rem_busy && !rem_done
                      && !pend_alarm_reg && !pend_wake_reg;
    assign s_accept = s_tvalid && s_tready;

    ctawt_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (s_accept),
        .op          (op_t'(s_tdata[3:0])),
        .normal_mode (s_tdata[4]),
        .sign        (s_tdata[5]),
        .cfg         (cfg_reg),
        .rem_wr      (rem_wr),
        .result      (core_result),
        .alarm_raw   (alarm_raw),
        .wake_raw    (wake_raw)
    );

    ctawt_skid u_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_accept),
        .push_data  (core_result),
        .push_ready (skid_ready),
        .out_valid  (m_tvalid),
        .out_data   (out_result),
        .out_ready  (m_tready)
    );

    assign m_tdata = {2'b00,
                      out_result.edit_mode,
                      out_result.wake_remaining,
                      out_result.wake_fired,
                      out_result.alarm_fired,
                      out_result.display_off,
                      out_result.display_refresh,
                      out_result.show_wake_mark,
                      out_result.show_dot,
                      out_result.show_minute,
                      out_result.show_hour,
                      out_result.minute,
                      out_result.hour};

    // A delay write must stall the input until the count is renormalized.
    a_delay_write_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr && ((reg_idx == REG_ALARM_DELAY) || (reg_idx == REG_WAKE_DELAY))
        |=> !s_tready)
        else $error("input accepted before timer count renormalized");

endmodule
